// ----- design/dfts_pkg.sv -----
`timescale 1ns / 1ps

package dfts_pkg;

   // default sizing
   localparam int MAX_TOKENS_DEF = 8;
   localparam int MAX_LENGTH_DEF = 256;

   // results per buffer, field widths and queue depth
   localparam int RESULT_CAP  = 8;
   localparam int CNT_W       = 4;
   localparam int IDX_W       = 3;
   localparam int QUEUE_DEPTH = 2;

   // reset values of the csr registers
   localparam logic [7:0] START_RST   = 8'd42;
   localparam logic [7:0] END_RST     = 8'd35;
   localparam logic [7:0] SEP_RST     = 8'd44;
   localparam logic [3:0] MAX_TOK_RST = 4'd8;

   typedef enum logic [1:0] {
      CSR_START   = 2'd0,
      CSR_END     = 2'd1,
      CSR_SEP     = 2'd2,
      CSR_MAX_TOK = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_START  = 3'd1,
      ST_NO_END    = 3'd2,
      ST_END_FIRST = 3'd3,
      ST_EMPTY     = 3'd4,
      ST_SAME_MARK = 3'd5,
      ST_TOO_LONG  = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      PH_WAIT   = 2'd0,
      PH_FRAME  = 2'd1,
      PH_CLOSED = 2'd2
   } phase_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_EMIT = 1'b1
   } back_state_type;

   typedef struct packed {
      logic [7:0]       start_mark;
      logic [7:0]       end_mark;
      logic [7:0]       sep_mark;
      logic [CNT_W-1:0] max_tok;
   } cfg_type;

   // one finished buffer, handed from the scanner to the emitter
   typedef struct packed {
      status_type                   status;
      logic                         single;
      logic [CNT_W-1:0]             total;
      logic                         ovf;
      logic [7:0]                   start;
      logic [RESULT_CAP-1:0][7:0]   bounds;
   } job_type;

endpackage

// ----- design/dfts_front.sv -----
`timescale 1ns / 1ps

module dfts_front #(
   parameter int MAX_TOKENS = dfts_pkg::MAX_TOKENS_DEF,
   parameter int MAX_LENGTH = dfts_pkg::MAX_LENGTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  dfts_pkg::cfg_type cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_data_byte,
   input  logic              req_end_of_buffer,
   output logic              job_push,
   output dfts_pkg::job_type job_data,
   input  logic              job_full
);
   import dfts_pkg::*;

   localparam int LIMIT_MAX = (MAX_TOKENS < RESULT_CAP) ? MAX_TOKENS : RESULT_CAP;
   localparam int PCNT_W    = $clog2(MAX_LENGTH + 1);

   phase_type         phase_ff, phase_in, phase_nx;
   status_type        err_ff, err_in, err_nx, status;
   logic [PCNT_W-1:0] pos_ff, pos_in;
   logic [PCNT_W-1:0] start_ff, start_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, cnt_nx, limit;
   logic              prev_ff, prev_in, prev_nx;
   logic              ovf_ff, ovf_in, ovf_nx;
   logic [7:0]        bnd_ff [LIMIT_MAX];
   logic [7:0]        bnd_in [LIMIT_MAX];
   logic              accept, last, in_range, scan;
   logic              is_start, is_end, is_sep, close_tok, room;

   assign req_ready = !job_full;
   assign accept    = req_valid && req_ready;
   assign last      = accept && req_end_of_buffer;
   assign in_range  = pos_ff < PCNT_W'(MAX_LENGTH);
   assign scan      = accept && in_range;
   assign is_start  = req_data_byte == cfg.start_mark;
   assign is_end    = req_data_byte == cfg.end_mark;
   assign is_sep    = req_data_byte == cfg.sep_mark;
   assign room      = cnt_ff < limit;

   // zero acts as one, large values clip to the table size
   always_comb begin
      if (cfg.max_tok == '0) begin
         limit = CNT_W'(1);
      end else if (cfg.max_tok > CNT_W'(LIMIT_MAX)) begin
         limit = CNT_W'(LIMIT_MAX);
      end else begin
         limit = cfg.max_tok;
      end
   end

   // frame phase
   always_comb begin
      phase_nx = phase_ff;
      if (scan) begin
         case (phase_ff)
            PH_WAIT: begin
               if (is_start) begin
                  phase_nx = (is_end || err_ff == ST_END_FIRST) ? PH_CLOSED : PH_FRAME;
               end
            end
            PH_FRAME: begin
               if (is_end) begin
                  phase_nx = PH_CLOSED;
               end
            end
            default: ;
         endcase
      end
      phase_in = last ? PH_WAIT : phase_nx;
   end

   // error, token count and boundary capture
   always_comb begin
      err_nx    = err_ff;
      start_in  = start_ff;
      cnt_nx    = cnt_ff;
      prev_nx   = prev_ff;
      ovf_nx    = ovf_ff;
      close_tok = 1'b0;
      if (accept && !in_range) begin
         err_nx = ST_TOO_LONG;
      end else if (scan) begin
         case (phase_ff)
            PH_WAIT: begin
               if (is_start) begin
                  if (is_end) begin
                     err_nx = ST_SAME_MARK;
                  end else if (err_ff != ST_END_FIRST) begin
                     start_in = pos_ff;
                     cnt_nx   = '0;
                     prev_nx  = 1'b0;
                  end
               end else if (is_end) begin
                  err_nx = ST_END_FIRST;
               end
            end
            PH_FRAME: begin
               if (is_end) begin
                  if (pos_ff == start_ff + PCNT_W'(1)) begin
                     err_nx = ST_EMPTY;
                  end else if (!prev_ff) begin
                     close_tok = 1'b1;
                  end
               end else if (is_sep) begin
                  close_tok = 1'b1;
                  prev_nx   = 1'b1;
               end else begin
                  prev_nx = 1'b0;
               end
            end
            default: ;
         endcase
      end
      if (close_tok) begin
         if (room) begin
            cnt_nx = cnt_ff + CNT_W'(1);
         end else begin
            ovf_nx = 1'b1;
         end
      end
      for (int i = 0; i < LIMIT_MAX; i++) begin
         bnd_in[i] = (close_tok && room && cnt_ff == CNT_W'(i)) ? 8'(pos_ff) : bnd_ff[i];
      end
   end

   // buffer status, length overrun first
   always_comb begin
      if (err_nx == ST_TOO_LONG) begin
         status = ST_TOO_LONG;
      end else if (phase_nx == PH_WAIT) begin
         status = ST_NO_START;
      end else if (phase_nx == PH_FRAME) begin
         status = ST_NO_END;
      end else begin
         status = err_nx;
      end
   end

   // scan state clears after the final byte
   always_comb begin
      err_in  = last ? ST_OK : err_nx;
      cnt_in  = last ? '0 : cnt_nx;
      prev_in = last ? 1'b0 : prev_nx;
      ovf_in  = last ? 1'b0 : ovf_nx;
      if (last) begin
         pos_in = '0;
      end else if (scan) begin
         pos_in = pos_ff + PCNT_W'(1);
      end else begin
         pos_in = pos_ff;
      end
   end

   assign job_push        = last;
   assign job_data.status = status;
   assign job_data.single = (status != ST_OK) || (cnt_nx == '0);
   assign job_data.total  = cnt_nx;
   assign job_data.ovf    = ovf_nx;
   assign job_data.start  = 8'(start_in);

   for (genvar g = 0; g < RESULT_CAP; g++) begin : g_bounds
      if (g < LIMIT_MAX) begin : g_used
         assign job_data.bounds[g] = bnd_in[g];
      end else begin : g_unused
         assign job_data.bounds[g] = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         err_ff   <= ST_OK;
         pos_ff   <= '0;
         cnt_ff   <= '0;
         prev_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         err_ff   <= err_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
         prev_ff  <= prev_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      bnd_ff   <= bnd_in;
   end

endmodule

// ----- design/dfts_queue.sv -----
`timescale 1ns / 1ps

module dfts_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dfts_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output dfts_pkg::job_type head
);
   import dfts_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

   job_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic              do_push, do_pop;

   assign full    = occ_ff == OCC_W'(QUEUE_DEPTH);
   assign valid   = occ_ff != '0;
   assign head    = entry_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      occ_in = occ_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (do_pop && !do_push) begin
         occ_in = occ_ff - OCC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         occ_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ----- design/dfts_back.sv -----
`timescale 1ns / 1ps

module dfts_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       job_valid,
   input  dfts_pkg::job_type          job_head,
   output logic                       job_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [2:0]                 rsp_frame_status,
   output logic [dfts_pkg::IDX_W-1:0] rsp_token_index,
   output logic [7:0]                 rsp_token_first,
   output logic [7:0]                 rsp_token_end,
   output logic [dfts_pkg::CNT_W-1:0] rsp_token_total,
   output logic                       rsp_overflowed,
   output logic                       rsp_last_result
);
   import dfts_pkg::*;

   back_state_type   state_ff, state_in;
   job_type          job_ff, job_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [7:0]       prev_end_ff, prev_end_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   logic [IDX_W-1:0] index_ff, index_in;
   logic [7:0]       first_ff, first_in, end_ff, end_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic             ovf_ff, ovf_in, last_ff, last_in;
   logic             out_free, emit, final_now;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign final_now = job_ff.single || (CNT_W'(k_ff) + CNT_W'(1) == job_ff.total);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (out_free && final_now) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      job_pop = 1'b0;
      emit    = 1'b0;
      case (state_ff)
         BK_IDLE: job_pop = job_valid;
         BK_EMIT: emit    = out_free;
         default: ;
      endcase
   end

   // result fields and job bookkeeping
   always_comb begin
      job_in      = job_ff;
      k_in        = k_ff;
      prev_end_in = prev_end_ff;
      if (job_ff.single) begin
         status_in = job_ff.status;
         index_in  = '0;
         first_in  = 8'h00;
         end_in    = 8'h00;
         total_in  = '0;
         ovf_in    = 1'b0;
         last_in   = 1'b1;
      end else begin
         status_in = ST_OK;
         index_in  = k_ff;
         first_in  = ((k_ff == '0) ? job_ff.start : prev_end_ff) + 8'd1;
         end_in    = job_ff.bounds[0];
         total_in  = job_ff.total;
         ovf_in    = job_ff.ovf;
         last_in   = final_now;
      end
      if (job_pop) begin
         job_in = job_head;
         k_in   = '0;
      end else if (emit) begin
         job_in.bounds = {8'h00, job_ff.bounds[RESULT_CAP-1:1]};
         k_in          = k_ff + IDX_W'(1);
         prev_end_in   = job_ff.bounds[0];
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      k_ff        <= k_in;
      prev_end_ff <= prev_end_in;
      if (emit) begin
         status_ff <= status_in;
         index_ff  <= index_in;
         first_ff  <= first_in;
         end_ff    <= end_in;
         total_ff  <= total_in;
         ovf_ff    <= ovf_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_status = status_ff;
   assign rsp_token_index  = index_ff;
   assign rsp_token_first  = first_ff;
   assign rsp_token_end    = end_ff;
   assign rsp_token_total  = total_ff;
   assign rsp_overflowed   = ovf_ff;
   assign rsp_last_result  = last_ff;

endmodule

// ----- design/delimited_frame_token_splitter.sv -----
`timescale 1ns / 1ps

// delimited frame token splitter
// req channel: one buffer byte per word (req_data_byte), req_end_of_buffer high on
//   the final byte. bytes are taken one per cycle while the frame queue has room.
// rsp channel: at buffer end, one word per token (start position, end position,
//   index, total, overflow) or a single status word for a malformed buffer;
//   rsp_last_result marks the final word of a buffer.
// csr channel: csr_index picks start marker, end marker, separator or token limit,
//   csr_wdata carries the value; always ready, write only while idle.
// results: the first result word follows the final byte through the frame queue and
//   the emitter, then one word per cycle within a buffer while rsp_ready is high.
// throughput: one byte per cycle while the queue has room, set by the single-byte scanner.
// a two-entry frame queue sits between scanner and emitter, so the next buffer
//   scans while the previous one is still being emitted.
// reset: scan state, queue and output register clear, csr values return to
//   '*', '#', ',' and 8 tokens.
// rsp stall: the output register holds its word, the emitter waits, the queue
//   fills, and req_ready drops once both queue entries hold finished buffers.
module delimited_frame_token_splitter #(
   parameter int MAX_TOKENS = dfts_pkg::MAX_TOKENS_DEF,
   parameter int MAX_LENGTH = dfts_pkg::MAX_LENGTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_buffer,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_frame_status,
   output logic [2:0] rsp_token_index,
   output logic [7:0] rsp_token_first,
   output logic [7:0] rsp_token_end,
   output logic [3:0] rsp_token_total,
   output logic       rsp_overflowed,
   output logic       rsp_last_result,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import dfts_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    csr_write;
   logic    job_push, job_full, job_pop, job_valid;
   job_type job_data, job_head;

   // csr registers, a write takes effect in the cycle after it is accepted
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_START:   cfg_in.start_mark = csr_wdata;
            CSR_END:     cfg_in.end_mark   = csr_wdata;
            CSR_SEP:     cfg_in.sep_mark   = csr_wdata;
            CSR_MAX_TOK: cfg_in.max_tok    = csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_mark <= START_RST;
         cfg_ff.end_mark   <= END_RST;
         cfg_ff.sep_mark   <= SEP_RST;
         cfg_ff.max_tok    <= MAX_TOK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // scanner: classifies each byte, keeps token boundaries, closes the buffer
   dfts_front #(
      .MAX_TOKENS (MAX_TOKENS),
      .MAX_LENGTH (MAX_LENGTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .job_push          (job_push),
      .job_data          (job_data),
      .job_full          (job_full)
   );

   // finished buffers waiting for the emitter
   dfts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_data),
      .full      (job_full),
      .pop       (job_pop),
      .valid     (job_valid),
      .head      (job_head)
   );

   // emitter: walks the boundaries, one result word per cycle while the receiver is ready
   dfts_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (job_valid),
      .job_head         (job_head),
      .job_pop          (job_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_status (rsp_frame_status),
      .rsp_token_index  (rsp_token_index),
      .rsp_token_first  (rsp_token_first),
      .rsp_token_end    (rsp_token_end),
      .rsp_token_total  (rsp_token_total),
      .rsp_overflowed   (rsp_overflowed),
      .rsp_last_result  (rsp_last_result)
   );

endmodule

// ----- design/dfts_checker.sv -----
`timescale 1ns / 1ps

module dfts_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_frame_status,
   input logic [2:0] rsp_token_index,
   input logic [7:0] rsp_token_first,
   input logic [7:0] rsp_token_end,
   input logic [3:0] rsp_token_total,
   input logic       rsp_overflowed,
   input logic       rsp_last_result
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_status)
         && $stable(rsp_token_index) && $stable(rsp_token_first)
         && $stable(rsp_token_end) && $stable(rsp_last_result))
      else $error("rsp word changed while stalled");

   // error status is a lone word with cleared total, index and overflow fields
   a_status_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_status != 3'd0 |-> rsp_last_result
         && rsp_token_total == 4'd0 && rsp_token_index == 3'd0 && !rsp_overflowed)
      else $error("status word carries token fields");

   // token words count up to the total and mark the last one
   a_token_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_status == 3'd0 && rsp_token_total != 4'd0
         |-> ({1'b0, rsp_token_index} < rsp_token_total)
         && (rsp_last_result == ({1'b0, rsp_token_index} + 4'd1 == rsp_token_total)))
      else $error("token index out of order with total");

   // a token word that is not last is followed by the next index
   a_token_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_frame_status == 3'd0 && !rsp_last_result
         ##1 rsp_valid |-> rsp_token_index == $past(rsp_token_index) + 3'd1)
      else $error("token index skipped");

   // output register empty right after reset
   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind delimited_frame_token_splitter dfts_checker u_dfts_checker (.*);

// ----- tb/sv/delimited_frame_token_splitter_test.sv -----
`timescale 1ns / 1ps

module delimited_frame_token_splitter_test;
   import dfts_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int HOLD_CYCLES    = 200;  // long receiver hold-off, fills the frame queue
   localparam int DRAIN_CYCLES   = 16;   // well past the result latency
   localparam int PHASE_BYTES    = 12;   // random bytes per csr setting
   localparam int MIN_WORDS      = 48;   // keep going until this many result words are due
   localparam int N_SETTINGS     = 7;
   localparam int PRESSURE_PHASE = 5;
   localparam int DIRECTED_LEN   = 25;

   // one result word as the block should present it
   typedef struct packed {
      status_type status;
      logic [2:0] index;
      logic [7:0] first_pos;
      logic [7:0] end_pos;
      logic [3:0] total;
      logic       ovf;
      logic       last;
   } token_word_t;

   // directed byte; has_want marks a buffer end whose status is known up front
   typedef struct packed {
      logic [7:0] data;
      logic       eob;
      logic       has_want;
      status_type want;
   } dir_row_t;

   typedef struct packed {
      logic [7:0] open_mark;
      logic [7:0] close_mark;
      logic [7:0] sep_mark;
      logic [3:0] tok_limit;
   } setting_t;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'd0;
   logic       req_end_of_buffer = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_frame_status;
   logic [2:0] rsp_token_index;
   logic [7:0] rsp_token_first;
   logic [7:0] rsp_token_end;
   logic [3:0] rsp_token_total;
   logic       rsp_overflowed;
   logic       rsp_last_result;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = CSR_START;
   logic [7:0] csr_wdata = 8'd0;

   delimited_frame_token_splitter u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_status  (rsp_frame_status),
      .rsp_token_index   (rsp_token_index),
      .rsp_token_first   (rsp_token_first),
      .rsp_token_end     (rsp_token_end),
      .rsp_token_total   (rsp_token_total),
      .rsp_overflowed    (rsp_overflowed),
      .rsp_last_result   (rsp_last_result),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // splitter state as the testbench tracks it
   // ---------------------------------------------------------------

   // csr copies
   logic [7:0] cfg_start, cfg_end, cfg_sep;
   logic [3:0] cfg_max;

   // scan state of the buffer in flight
   int unsigned scan_pos;
   phase_type   frame_phase;
   status_type  scan_err;
   logic [7:0]  bound_pos [0:MAX_TOKENS_DEF];
   int unsigned tok_count;
   logic        after_sep;
   logic        tok_ovf;

   token_word_t found_words[$];    // words caused by the last byte
   token_word_t awaited_words[$];  // words still due from the block
   logic [7:0]  buf_bytes[$];      // buffer being sent

   // bookkeeping
   int error_count  = 0;
   int bytes_sent   = 0;
   int buffers_sent = 0;
   int words_due    = 0;
   int words_seen   = 0;
   int status_words = 0;
   int ovf_words    = 0;
   int cycle_count  = 0;

   // idling knobs, percent of cycles
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   bit hold_request  = 1'b0;
   int hold_left     = 0;

   dir_row_t directed_rows [DIRECTED_LEN];
   setting_t settings [N_SETTINGS];

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= 40)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   // ---------------------------------------------------------------
   // frame splitting predictor
   // ---------------------------------------------------------------

   function automatic void clear_frame();
      scan_pos    = 0;
      frame_phase = PH_WAIT;
      scan_err    = ST_OK;
      tok_count   = 0;
      after_sep   = 1'b0;
      tok_ovf     = 1'b0;
      foreach (bound_pos[i]) bound_pos[i] = 8'd0;
   endfunction

   // 0 acts as 1, anything above the build limit is clipped
   function automatic int unsigned token_cap();
      int unsigned lim;
      lim = cfg_max;
      if (lim == 0) lim = 1;
      if (lim > MAX_TOKENS_DEF) lim = MAX_TOKENS_DEF;
      return lim;
   endfunction

   function automatic void close_token(input int unsigned pos);
      if (tok_count < token_cap()) begin
         tok_count++;
         bound_pos[tok_count] = pos[7:0];
      end else begin
         tok_ovf = 1'b1;
      end
   endfunction

   // consume one byte; at buffer end fill found_words and restart the scan
   task automatic split_byte(input logic [7:0] b, input logic eob);
      status_type  st;
      token_word_t w;
      int unsigned k;
      found_words.delete();
      if (scan_pos >= MAX_LENGTH_DEF) begin
         // bytes past the length limit are not looked at
         scan_err = ST_TOO_LONG;
      end else begin
         case (frame_phase)
            PH_WAIT: begin
               if (b == cfg_start) begin
                  if (b == cfg_end) begin
                     scan_err    = ST_SAME_MARK;
                     frame_phase = PH_CLOSED;
                  end else if (scan_err == ST_END_FIRST) begin
                     frame_phase = PH_CLOSED;
                  end else begin
                     frame_phase  = PH_FRAME;
                     bound_pos[0] = scan_pos[7:0];
                     tok_count    = 0;
                     after_sep    = 1'b0;
                  end
               end else if (b == cfg_end) begin
                  scan_err = ST_END_FIRST;
               end
            end
            PH_FRAME: begin
               // end marker wins over separator when both match
               if (b == cfg_end) begin
                  if (scan_pos == bound_pos[0] + 1) scan_err = ST_EMPTY;
                  else if (!after_sep) close_token(scan_pos);
                  frame_phase = PH_CLOSED;
               end else if (b == cfg_sep) begin
                  close_token(scan_pos);
                  after_sep = 1'b1;
               end else begin
                  after_sep = 1'b0;
               end
            end
            default: ;
         endcase
         scan_pos++;
      end
      if (eob) begin
         if (scan_err == ST_TOO_LONG) st = ST_TOO_LONG;
         else if (frame_phase == PH_WAIT) st = ST_NO_START;
         else if (frame_phase == PH_FRAME) st = ST_NO_END;
         else st = scan_err;
         if (st != ST_OK || tok_count == 0) begin
            w        = '0;
            w.status = st;
            w.last   = 1'b1;
            found_words.push_back(w);
         end else begin
            for (k = 0; k < tok_count; k++) begin
               w.status    = ST_OK;
               w.index     = k[2:0];
               w.first_pos = bound_pos[k] + 8'd1;
               w.end_pos   = bound_pos[k + 1];
               w.total     = tok_count[3:0];
               w.ovf       = tok_ovf;
               w.last      = (k + 1 == tok_count);
               found_words.push_back(w);
            end
         end
         clear_frame();
      end
   endtask

   // ---------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------

   // offer one byte, wait for the handshake, then queue what it causes
   task automatic send_word(input logic [7:0] b, input logic eob,
                            input logic has_want, input status_type want);
      token_word_t w;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_end_of_buffer <= eob;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      split_byte(b, eob);
      if (has_want) begin
         // directed rows carry their status word typed in
         w        = '0;
         w.status = want;
         w.last   = 1'b1;
         found_words.delete();
         found_words.push_back(w);
      end
      foreach (found_words[i]) begin
         awaited_words.push_back(found_words[i]);
         words_due++;
         if (found_words[i].status != ST_OK) status_words++;
         if (found_words[i].ovf) ovf_words++;
      end
      if (eob) buffers_sent++;
   endtask

   task automatic send_buffer();
      foreach (buf_bytes[i])
         send_word(buf_bytes[i], i == buf_bytes.size() - 1, 1'b0, ST_OK);
   endtask

   function automatic logic [7:0] random_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] marker_or_noise();
      case ($urandom_range(0, 3))
         0: return cfg_start;
         1: return cfg_end;
         2: return cfg_sep;
         default: return random_byte();
      endcase
   endfunction

   // mostly well-formed frames with random tokens, some noise and cut-off frames
   task automatic build_buffer();
      int roll, ntok, t;
      buf_bytes.delete();
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         repeat ($urandom_range(0, 2)) buf_bytes.push_back(random_byte());
         buf_bytes.push_back(cfg_start);
         ntok = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
         for (t = 0; t < ntok; t++) begin
            repeat ($urandom_range(0, 3)) buf_bytes.push_back(random_byte());
            if (t != ntok - 1) buf_bytes.push_back(cfg_sep);
         end
         if ($urandom_range(0, 3) == 0) buf_bytes.push_back(cfg_sep);
         buf_bytes.push_back(cfg_end);
         repeat ($urandom_range(0, 2)) buf_bytes.push_back(random_byte());
      end else if (roll < 85) begin
         repeat ($urandom_range(1, 8)) buf_bytes.push_back(marker_or_noise());
      end else begin
         // frame that never closes
         buf_bytes.push_back(cfg_start);
         repeat ($urandom_range(0, 5))
            buf_bytes.push_back($urandom_range(0, 1) ? cfg_sep : random_byte());
      end
   endtask

   // write all four registers back to back, valid held high between them
   task automatic load_settings(input setting_t s);
      csr_index_type idx [4];
      logic [7:0]    val [4];
      int            i;
      idx = '{CSR_START, CSR_END, CSR_SEP, CSR_MAX_TOK};
      val = '{s.open_mark, s.close_mark, s.sep_mark, {4'd0, s.tok_limit}};
      for (i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         do @(posedge clock); while (!csr_ready);
         case (idx[i])
            CSR_START:   cfg_start = val[i];
            CSR_END:     cfg_end   = val[i];
            CSR_SEP:     cfg_sep   = val[i];
            CSR_MAX_TOK: cfg_max   = val[i][3:0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // every due word back, then let the emitter settle
   task automatic wait_drained();
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // receiver: random stalls, plus one long hold-off on request
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    <= HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // ---------------------------------------------------------------
   // result check, oldest expectation first
   // ---------------------------------------------------------------
   always @(posedge clock) begin : check_words
      token_word_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         words_seen++;
         if (awaited_words.size() == 0) begin
            report_mismatch($sformatf("result word with nothing due, status %0d",
                                      rsp_frame_status));
         end else begin
            want = awaited_words.pop_front();
            if (rsp_frame_status !== want.status)
               report_mismatch($sformatf("frame_status %0d, want %0d",
                                         rsp_frame_status, want.status));
            if (rsp_token_index !== want.index)
               report_mismatch($sformatf("token_index %0d, want %0d",
                                         rsp_token_index, want.index));
            if (rsp_token_first !== want.first_pos)
               report_mismatch($sformatf("token_first %0d, want %0d",
                                         rsp_token_first, want.first_pos));
            if (rsp_token_end !== want.end_pos)
               report_mismatch($sformatf("token_end %0d, want %0d",
                                         rsp_token_end, want.end_pos));
            if (rsp_token_total !== want.total)
               report_mismatch($sformatf("token_total %0d, want %0d",
                                         rsp_token_total, want.total));
            if (rsp_overflowed !== want.ovf)
               report_mismatch($sformatf("overflowed %0b, want %0b",
                                         rsp_overflowed, want.ovf));
            if (rsp_last_result !== want.last)
               report_mismatch($sformatf("last_result %0b, want %0b",
                                         rsp_last_result, want.last));
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d words still due",
               cycle_count, awaited_words.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   initial begin : stimulus
      int ph, phase_bytes, i;

      // directed buffers under reset csr values: '*' opens, '#' closes, ',' splits
      directed_rows = '{
         // start then end right away: empty frame
         '{8'h2A, 1'b0, 1'b0, ST_OK}, '{8'h23, 1'b1, 1'b1, ST_EMPTY},
         // lone zero byte: no start
         '{8'h00, 1'b1, 1'b1, ST_NO_START},
         // end marker, then start: end before start
         '{8'h23, 1'b0, 1'b0, ST_OK}, '{8'h2A, 1'b1, 1'b1, ST_END_FIRST},
         // frame left open
         '{8'h2A, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b1, 1'b1, ST_NO_END},
         // end marker with no start after it reads as no start
         '{8'h23, 1'b1, 1'b1, ST_NO_START},
         // two tokens, separator right before the end adds nothing
         '{8'h2A, 1'b0, 1'b0, ST_OK}, '{8'h61, 1'b0, 1'b0, ST_OK},
         '{8'h2C, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK},
         '{8'h2C, 1'b0, 1'b0, ST_OK}, '{8'h23, 1'b1, 1'b0, ST_OK},
         // empty tokens and a start byte used as data
         '{8'h2A, 1'b0, 1'b0, ST_OK}, '{8'h2C, 1'b0, 1'b0, ST_OK},
         '{8'h2C, 1'b0, 1'b0, ST_OK}, '{8'h2A, 1'b0, 1'b0, ST_OK},
         '{8'h23, 1'b1, 1'b0, ST_OK},
         // leading noise, one token, bytes after the close are ignored
         '{8'h55, 1'b0, 1'b0, ST_OK}, '{8'h2A, 1'b0, 1'b0, ST_OK},
         '{8'hAA, 1'b0, 1'b0, ST_OK}, '{8'h23, 1'b0, 1'b0, ST_OK},
         '{8'h2A, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b1, 1'b0, ST_OK}
      };

      // marker extremes, limits of 1, 0 and 15, equal markers, separator equal to
      // the end marker, then to the start marker, then reset markers with limits 2 and 8
      settings = '{
         '{8'h00, 8'hFF, 8'h7F, 4'd1},
         '{8'hFF, 8'h00, 8'h80, 4'd0},
         '{8'h41, 8'h41, 8'h2C, 4'd15},
         '{8'h5B, 8'h5D, 8'h5D, 4'd3},
         '{8'h3C, 8'h3E, 8'h3C, 4'd8},
         '{8'h2A, 8'h23, 8'h2C, 4'd2},
         '{8'h2A, 8'h23, 8'h2C, 4'd8}
      };

      cfg_start = START_RST;
      cfg_end   = END_RST;
      cfg_sep   = SEP_RST;
      cfg_max   = MAX_TOK_RST;
      clear_frame();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 24;
      rsp_idle_pct  = 66;
      for (i = 0; i < DIRECTED_LEN; i++)
         send_word(directed_rows[i].data, directed_rows[i].eob,
                   directed_rows[i].has_want, directed_rows[i].want);
      req_valid <= 1'b0;

      for (ph = 0; ph < N_SETTINGS; ph++) begin
         // csr writes only with the block idle
         wait_drained();
         if (ph < 3) begin
            send_idle_pct = 24;
            rsp_idle_pct  = 66;
         end else if (ph < 5) begin
            send_idle_pct = 66;
            rsp_idle_pct  = 24;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         load_settings(settings[ph]);

         if (ph == PRESSURE_PHASE) begin
            // receiver stops for a long while, short frames back up the queue
            hold_request = 1'b1;
            repeat (10) begin
               buf_bytes.delete();
               buf_bytes.push_back(cfg_start);
               buf_bytes.push_back(random_byte());
               buf_bytes.push_back(cfg_end);
               send_buffer();
            end
         end

         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES ||
                (ph == N_SETTINGS - 1 && words_due < MIN_WORDS)) begin
            build_buffer();
            phase_bytes += buf_bytes.size();
            send_buffer();
         end
         req_valid <= 1'b0;
      end

      wait_drained();
      $display("sent %0d bytes in %0d buffers over %0d csr settings plus reset values",
               bytes_sent, buffers_sent, N_SETTINGS);
      $display("checked %0d result words, %0d status words, %0d with overflow set",
               words_seen, status_words, ovf_words);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- sim.f -----
design/dfts_pkg.sv
design/dfts_front.sv
design/dfts_queue.sv
design/dfts_back.sv
design/delimited_frame_token_splitter.sv
design/dfts_checker.sv
tb/sv/delimited_frame_token_splitter_test.sv
